[design/wac_pkg.sv]
`timescale 1ns / 1ps

package wac_pkg;

    // Restoring divider: one initial compare plus seventeen quotient steps.
    localparam int DIV_STAGES  = 18;
    localparam int Q_W         = 18;
    // Bitwise square root of a 64-bit radicand: one result bit per stage.
    localparam int SQRT_STAGES = 32;
    localparam int WEIGHT_BITS = 16;
    localparam logic [16:0] WEIGHT_ONE = 17'h10000;

    // Fields that travel beside the divider.
    typedef struct packed {
        logic [31:0] position;
        logic [31:0] position_err;
        logic [31:0] value_a;
        logic [31:0] value_b;
        logic [31:0] stat_err_a;
        logic [31:0] syst_err_a;
        logic [31:0] stat_err_b;
        logic [31:0] syst_err_b;
        logic        degenerate;
    } div_side_t;

    // Fields that travel beside the square root units.
    typedef struct packed {
        logic [31:0] position;
        logic [31:0] position_err;
        logic [31:0] value;
        logic [16:0] weight;
        logic        sat_stat;
        logic        sat_syst;
        logic        degenerate;
    } sqrt_side_t;

endpackage

[design/weighted_average_combine_top.sv]
`timescale 1ns / 1ps
// Throughput: one item per cycle; busy is always low since nothing can stall.
// The depth is set by the 18-stage weight divider and the 32-stage square roots.
// Reset (rst_n, asynchronous, active low) clears only the valid bits of the pipeline;
// the receiver cannot stall, so no item is ever held back in the pipeline.
module weighted_average_combine_top
    import wac_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] position,
    input  logic [31:0] position_err,
    input  logic [31:0] value_a,
    input  logic [31:0] stat_err_a,
    input  logic [31:0] syst_err_a,
    input  logic [31:0] value_b,
    input  logic [31:0] stat_err_b,
    input  logic [31:0] syst_err_b,
    output logic        done,
    output logic [31:0] out_position,
    output logic [31:0] out_position_err,
    output logic [31:0] combined_value,
    output logic [31:0] combined_stat_err,
    output logic [31:0] combined_syst_err,
    output logic [16:0] weight_a,
    output logic        degenerate
);

    // The pipeline never holds an item back, so a new item is taken every cycle.
    assign busy = 1'b0;

    logic accept;
    assign accept = start & ~busy;

    // Stage 1: the four error squares, one multiplier each.
    logic        v1_reg;
    div_side_t   s1_reg;
    logic [63:0] sqa_s_reg, sqa_y_reg, sqb_s_reg, sqb_y_reg;

    // Stage 2: the total variance of each measurement (65 bits).
    logic        v2_reg;
    div_side_t   s2_reg;
    logic [64:0] var_a_reg, var_b_reg;

    // Stage 3: the sum of both variances, scaled below 2^64 for the divider.
    logic        v3_reg;
    div_side_t   s3_reg;
    div_side_t   s3_next;
    logic [63:0] num_reg, den_reg;

    logic [65:0] tot;
    logic [65:0] vb_wide;
    logic [63:0] num_next, den_next;
    logic        deg_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg.position     <= position;
        s1_reg.position_err <= position_err;
        s1_reg.value_a      <= value_a;
        s1_reg.value_b      <= value_b;
        s1_reg.stat_err_a   <= stat_err_a;
        s1_reg.syst_err_a   <= syst_err_a;
        s1_reg.stat_err_b   <= stat_err_b;
        s1_reg.syst_err_b   <= syst_err_b;
        s1_reg.degenerate   <= 1'b0;
        sqa_s_reg <= 64'(stat_err_a) * 64'(stat_err_a);
        sqa_y_reg <= 64'(syst_err_a) * 64'(syst_err_a);
        sqb_s_reg <= 64'(stat_err_b) * 64'(stat_err_b);
        sqb_y_reg <= 64'(syst_err_b) * 64'(syst_err_b);

        s2_reg    <= s1_reg;
        var_a_reg <= {1'b0, sqa_s_reg} + {1'b0, sqa_y_reg};
        var_b_reg <= {1'b0, sqb_s_reg} + {1'b0, sqb_y_reg};

        s3_reg  <= s3_next;
        num_reg <= num_next;
        den_reg <= den_next;
    end

    // Shift the variance sum right by 0, 1 or 2 so that it fits 64 bits, and the
    // numerator by the same amount.
    always_comb
    begin
        tot      = {1'b0, var_a_reg} + {1'b0, var_b_reg};
        vb_wide  = {1'b0, var_b_reg};
        deg_next = (tot == '0);
        s3_next            = s2_reg;
        s3_next.degenerate = deg_next;
        if (tot[65])
        begin
            den_next = tot[65:2];
            num_next = vb_wide[65:2];
        end
        else if (tot[64])
        begin
            den_next = tot[64:1];
            num_next = vb_wide[64:1];
        end
        else
        begin
            den_next = tot[63:0];
            num_next = vb_wide[63:0];
        end
    end

    // Weight divider with its side data delayed to match.
    logic           div_valid;
    logic [Q_W-1:0] div_quot;
    div_side_t      dside_reg [DIV_STAGES];

    wac_frac_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .num       (num_reg),
        .den       (den_reg),
        .out_valid (div_valid),
        .quot      (div_quot)
    );

    always_ff @(posedge clk)
    begin
        dside_reg[0] <= s3_reg;
        for (int i = 1; i < DIV_STAGES; i++)
        begin
            dside_reg[i] <= dside_reg[i-1];
        end
    end

    // Stage 4: round the quotient half up to the Q1.16 weight.
    logic        v4_reg;
    div_side_t   s4_reg;
    logic [16:0] wa4_reg, wb4_reg;
    logic [Q_W-1:0] q_round;
    assign q_round = div_quot + {{(Q_W-1){1'b0}}, 1'b1};

    // Stage 5: weight times value and errors.
    logic               v5_reg;
    div_side_t          s5_reg;
    logic [16:0]        wa5_reg;
    logic signed [49:0] pa_reg, pb_reg;
    logic [48:0]        psa_reg, psb_reg, pya_reg, pyb_reg;

    // Stage 6: rounded weighted value and scaled errors.
    logic        v6_reg;
    sqrt_side_t  s6_reg;
    logic [32:0] esa_reg, esb_reg, eya_reg, eyb_reg;
    logic signed [49:0] acc;
    logic signed [49:0] acc_rnd;

    // Stage 7: squares of the scaled errors.
    logic        v7_reg;
    sqrt_side_t  s7_reg;
    logic [65:0] qsa_reg, qsb_reg, qya_reg, qyb_reg;

    // Stage 8: quadrature sums, with saturation noted when they reach 2^64.
    logic        v8_reg;
    sqrt_side_t  s8_reg;
    sqrt_side_t  s8_next;
    logic [63:0] rad_s_reg, rad_y_reg;
    logic [66:0] sum_s, sum_y;

    always_comb
    begin
        acc     = pa_reg + pb_reg;
        acc_rnd = (acc + 50'sd32768) >>> WEIGHT_BITS;
        sum_s   = {1'b0, qsa_reg} + {1'b0, qsb_reg};
        sum_y   = {1'b0, qya_reg} + {1'b0, qyb_reg};
        s8_next          = s7_reg;
        s8_next.sat_stat = (sum_s[66:64] != 3'd0);
        s8_next.sat_syst = (sum_y[66:64] != 3'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= div_valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_reg  <= dside_reg[DIV_STAGES-1];
        wa4_reg <= q_round[Q_W-1:1];
        wb4_reg <= WEIGHT_ONE - q_round[Q_W-1:1];

        s5_reg  <= s4_reg;
        wa5_reg <= wa4_reg;
        pa_reg  <= $signed({1'b0, wa4_reg}) * $signed(s4_reg.value_a);
        pb_reg  <= $signed({1'b0, wb4_reg}) * $signed(s4_reg.value_b);
        psa_reg <= 49'(wa4_reg) * 49'(s4_reg.stat_err_a);
        psb_reg <= 49'(wb4_reg) * 49'(s4_reg.stat_err_b);
        pya_reg <= 49'(wa4_reg) * 49'(s4_reg.syst_err_a);
        pyb_reg <= 49'(wb4_reg) * 49'(s4_reg.syst_err_b);

        s6_reg.position     <= s5_reg.position;
        s6_reg.position_err <= s5_reg.position_err;
        s6_reg.value        <= acc_rnd[31:0];
        s6_reg.weight       <= wa5_reg;
        s6_reg.sat_stat     <= 1'b0;
        s6_reg.sat_syst     <= 1'b0;
        s6_reg.degenerate   <= s5_reg.degenerate;
        esa_reg <= 33'((psa_reg + 49'd32768) >> WEIGHT_BITS);
        esb_reg <= 33'((psb_reg + 49'd32768) >> WEIGHT_BITS);
        eya_reg <= 33'((pya_reg + 49'd32768) >> WEIGHT_BITS);
        eyb_reg <= 33'((pyb_reg + 49'd32768) >> WEIGHT_BITS);

        s7_reg  <= s6_reg;
        qsa_reg <= 66'(esa_reg) * 66'(esa_reg);
        qsb_reg <= 66'(esb_reg) * 66'(esb_reg);
        qya_reg <= 66'(eya_reg) * 66'(eya_reg);
        qyb_reg <= 66'(eyb_reg) * 66'(eyb_reg);

        s8_reg    <= s8_next;
        rad_s_reg <= sum_s[63:0];
        rad_y_reg <= sum_y[63:0];
    end

    // Two square root units with the side data delayed alongside.
    logic [31:0] root_s, root_y;
    sqrt_side_t  rside_reg [SQRT_STAGES];
    logic        rv_reg    [SQRT_STAGES];

    wac_isqrt u_sqrt_stat (
        .clk      (clk),
        .radicand (rad_s_reg),
        .root     (root_s)
    );

    wac_isqrt u_sqrt_syst (
        .clk      (clk),
        .radicand (rad_y_reg),
        .root     (root_y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SQRT_STAGES; i++)
            begin
                rv_reg[i] <= 1'b0;
            end
        end
        else
        begin
            rv_reg[0] <= v8_reg;
            for (int i = 1; i < SQRT_STAGES; i++)
            begin
                rv_reg[i] <= rv_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rside_reg[0] <= s8_reg;
        for (int i = 1; i < SQRT_STAGES; i++)
        begin
            rside_reg[i] <= rside_reg[i-1];
        end
    end

    // Output register: a zero total variance clears every computed field, and a
    // quadrature sum that overflowed saturates its error.
    sqrt_side_t ro;
    assign ro = rside_reg[SQRT_STAGES-1];

    logic        done_reg;
    logic [31:0] out_position_reg;
    logic [31:0] out_position_err_reg;
    logic [31:0] combined_value_reg;
    logic [31:0] combined_stat_err_reg;
    logic [31:0] combined_syst_err_reg;
    logic [16:0] weight_a_reg;
    logic        degenerate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= rv_reg[SQRT_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        out_position_reg     <= ro.position;
        out_position_err_reg <= ro.position_err;
        degenerate_reg       <= ro.degenerate;
        if (ro.degenerate)
        begin
            combined_value_reg    <= '0;
            combined_stat_err_reg <= '0;
            combined_syst_err_reg <= '0;
            weight_a_reg          <= '0;
        end
        else
        begin
            combined_value_reg    <= ro.value;
            combined_stat_err_reg <= ro.sat_stat ? 32'hFFFF_FFFF : root_s;
            combined_syst_err_reg <= ro.sat_syst ? 32'hFFFF_FFFF : root_y;
            weight_a_reg          <= ro.weight;
        end
    end

    assign done              = done_reg;
    assign out_position      = out_position_reg;
    assign out_position_err  = out_position_err_reg;
    assign combined_value    = combined_value_reg;
    assign combined_stat_err = combined_stat_err_reg;
    assign combined_syst_err = combined_syst_err_reg;
    assign weight_a          = weight_a_reg;
    assign degenerate        = degenerate_reg;

endmodule

[design/wac_frac_div.sv]
`timescale 1ns / 1ps

module wac_frac_div
    import wac_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [63:0]      num,
    input  logic [63:0]      den,
    output logic             out_valid,
    output logic [Q_W-1:0]   quot
);

    // Computes floor(num * 2^17 / den) for num <= den, one quotient bit per stage.
    logic [63:0]    r_reg [DIV_STAGES];
    logic [63:0]    d_reg [DIV_STAGES];
    logic [Q_W-1:0] q_reg [DIV_STAGES];
    logic           v_reg [DIV_STAGES];

    logic first_ge;
    assign first_ge = (num >= den);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg[0] <= first_ge ? (num - den) : num;
        d_reg[0] <= den;
        q_reg[0] <= {{(Q_W-1){1'b0}}, first_ge};
    end

    for (genvar k = 1; k < DIV_STAGES; k++)
    begin : g_step
        logic [64:0] shl;
        logic        ge;
        logic [64:0] diff;

        assign shl  = {r_reg[k-1], 1'b0};
        assign ge   = (shl >= {1'b0, d_reg[k-1]});
        assign diff = shl - {1'b0, d_reg[k-1]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            r_reg[k] <= ge ? diff[63:0] : shl[63:0];
            d_reg[k] <= d_reg[k-1];
            q_reg[k] <= {q_reg[k-1][Q_W-2:0], ge};
        end
    end

    assign out_valid = v_reg[DIV_STAGES-1];
    assign quot      = q_reg[DIV_STAGES-1];

endmodule

[design/wac_isqrt.sv]
`timescale 1ns / 1ps

module wac_isqrt
    import wac_pkg::*;
(
    input  logic        clk,
    input  logic [63:0] radicand,
    output logic [31:0] root
);

    // Digit-by-digit square root; stage k tries the bit 2^(62-2k).
    logic [63:0] n_reg   [SQRT_STAGES];
    logic [63:0] res_reg [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++)
    begin : g_step
        logic [63:0] n_in;
        logic [63:0] res_in;
        logic [63:0] trial;
        logic [63:0] bitv;

        assign bitv  = 64'd1 << (62 - 2 * k);
        if (k == 0)
        begin : g_first
            assign n_in   = radicand;
            assign res_in = '0;
        end
        else
        begin : g_next
            assign n_in   = n_reg[k-1];
            assign res_in = res_reg[k-1];
        end
        assign trial = res_in + bitv;

        always_ff @(posedge clk)
        begin
            if (n_in >= trial)
            begin
                n_reg[k]   <= n_in - trial;
                res_reg[k] <= (res_in >> 1) + bitv;
            end
            else
            begin
                n_reg[k]   <= n_in;
                res_reg[k] <= res_in >> 1;
            end
        end
    end

    assign root = res_reg[SQRT_STAGES-1][31:0];

endmodule
